>>> rtl/assert_macros.svh
// Assertion macros used by the checker file ukl_chk.sv.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off during reset.
`define ASSERT_IMPLIES(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");

// Next-cycle implication, off during reset.
`define ASSERT_NEXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");

`endif

>>> rtl/ukl_pkg.sv
// Shared types and constants for the unordered key list table.
// No dependencies.
package ukl_pkg;

    localparam int CAPACITY_DEF = 16;
    localparam int KEY_W        = 32;
    localparam int REQ_W        = 2;
    localparam int STAT_W       = 2;
    localparam int POS_W        = 5;

    typedef enum logic [REQ_W-1:0] {
        REQ_SEARCH = 2'd0,
        REQ_INSERT = 2'd1,
        REQ_REMOVE = 2'd2
    } req_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE      = 2'd0,
        ST_NOT_FOUND = 2'd1,
        ST_FULL      = 2'd2,
        ST_DUPLICATE = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

endpackage

>>> rtl/ukl_req_if.sv
// Request channel: valid/ready plus request type and key.
// Depends on ukl_pkg.
interface ukl_req_if
    import ukl_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [REQ_W-1:0]        req_type;
    logic signed [KEY_W-1:0] key;

    modport source (output valid, output req_type, output key, input ready);
    modport sink   (input valid, input req_type, input key, output ready);
endinterface

>>> rtl/ukl_rsp_if.sv
// Response channel: valid/ready plus status, position and entry count.
// Depends on ukl_pkg.
interface ukl_rsp_if
    import ukl_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [STAT_W-1:0] status;
    logic [POS_W-1:0]  position;
    logic [POS_W-1:0]  count_after;

    modport source (output valid, output status, output position, output count_after,
                    input ready);
    modport sink   (input valid, input status, input position, input count_after,
                    output ready);
endinterface

>>> rtl/ukl_mem.sv
// Key storage: one write port, one read port with registered read data.
// Depends on ukl_pkg.
module ukl_mem
    import ukl_pkg::*;
#(
    parameter int DEPTH = CAPACITY_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [KEY_W-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [KEY_W-1:0] rd_data
);

    logic [KEY_W-1:0] mem [DEPTH];
    logic [KEY_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

>>> rtl/unordered_key_list_table.sv
// Unordered key list table. Keeps up to CAPACITY signed 32-bit keys packed in
// slots 0..count-1 of a single-port-read memory and serves one request at a
// time: search, insert (append, refused when full or duplicate) and remove
// (later entries shift down one slot). Every request gives exactly one
// response word. The memory is read once per cycle and one equality
// comparator checks one entry per cycle; a search or insert scans the stored
// entries, a remove scans to the hit slot and then moves each later entry
// down one slot, and an insert into a full table or an unused request type
// goes straight to the response. The request side is not ready while a
// request is in progress. A finished response sits in an output register, so
// a new request is taken while the previous response waits. Table contents
// are not cleared at reset.
// Depends on ukl_pkg, ukl_req_if, ukl_rsp_if, ukl_mem.
module unordered_key_list_table
    import ukl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)(
    input  logic      clk,
    input  logic      rst_n,
    ukl_req_if.sink   req,
    ukl_rsp_if.source rsp
);

    localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

    state_t            state_reg, state_next;
    logic [REQ_W-1:0]  op_reg, op_next;
    logic [KEY_W-1:0]  key_reg, key_next;
    logic [CW-1:0]     count_reg, count_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic              pend_reg, pend_next;
    logic [IW-1:0]     pend_idx_reg, pend_idx_next;
    status_t           status_reg, status_next;
    logic [POS_W-1:0]  pos_reg, pos_next;

    logic              out_valid_reg, out_valid_next;
    logic [STAT_W-1:0] out_status_reg, out_status_next;
    logic [POS_W-1:0]  out_pos_reg, out_pos_next;
    logic [POS_W-1:0]  out_count_reg, out_count_next;

    logic              mem_wr_en;
    logic [IW-1:0]     mem_wr_addr;
    logic [KEY_W-1:0]  mem_wr_data;
    logic              mem_rd_en;
    logic [KEY_W-1:0]  mem_rd_data;

    logic req_fire;
    logic hit;
    logic more;
    logic out_free;

    assign req_fire = req.valid && req.ready;
    assign hit      = pend_reg && (mem_rd_data == key_reg);
    assign more     = idx_reg < count_reg;
    assign out_free = !out_valid_reg || rsp.ready;

    ukl_mem #(
        .DEPTH (CAPACITY),
        .AW    (IW)
    ) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (idx_reg[IW-1:0]),
        .rd_data (mem_rd_data)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    case (req.req_type)
                        REQ_SEARCH, REQ_REMOVE: state_next = S_SCAN;
                        REQ_INSERT: state_next = (count_reg >= CAP_C) ? S_DONE : S_SCAN;
                        default:    state_next = S_DONE;
                    endcase
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    state_next = (op_reg == REQ_REMOVE) ? S_SHIFT : S_DONE;
                end
                else if (!more)
                begin
                    state_next = S_DONE;
                end
            end
            S_SHIFT:
            begin
                if (!more && !pend_reg)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath, memory control and outputs
    always_comb
    begin
        op_next         = op_reg;
        key_next        = key_reg;
        count_next      = count_reg;
        idx_next        = idx_reg;
        pend_next       = pend_reg;
        pend_idx_next   = pend_idx_reg;
        status_next     = status_reg;
        pos_next        = pos_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_pos_next    = out_pos_reg;
        out_count_next  = out_count_reg;
        mem_wr_en       = 1'b0;
        mem_wr_addr     = count_reg[IW-1:0];
        mem_wr_data     = key_reg;
        mem_rd_en       = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req_fire)
                begin
                    op_next     = req.req_type;
                    key_next    = req.key;
                    idx_next    = '0;
                    pend_next   = 1'b0;
                    status_next = ST_NOT_FOUND;
                    pos_next    = '0;
                    if (req.req_type == REQ_INSERT && count_reg >= CAP_C)
                    begin
                        status_next = ST_FULL;
                    end
                end
            end
            S_SCAN:
            begin
                if (hit)
                begin
                    pend_next = 1'b0;
                    case (op_reg)
                        REQ_SEARCH:
                        begin
                            status_next = ST_DONE;
                            pos_next    = POS_W'(pend_idx_reg);
                        end
                        REQ_INSERT:
                        begin
                            status_next = ST_DUPLICATE;
                            pos_next    = '0;
                        end
                        REQ_REMOVE:
                        begin
                            status_next = ST_DONE;
                            pos_next    = POS_W'(pend_idx_reg);
                            // shift source starts one past the hit
                            idx_next    = CW'(pend_idx_reg) + CW'(1);
                        end
                        default:
                        begin
                            status_next = ST_NOT_FOUND;
                        end
                    endcase
                end
                else if (more)
                begin
                    mem_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IW-1:0];
                    idx_next      = idx_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (op_reg == REQ_INSERT)
                    begin
                        mem_wr_en   = 1'b1;
                        count_next  = count_reg + CW'(1);
                        status_next = ST_DONE;
                        pos_next    = POS_W'(count_reg + CW'(1));
                    end
                end
            end
            S_SHIFT:
            begin
                if (pend_reg)
                begin
                    mem_wr_en   = 1'b1;
                    mem_wr_addr = pend_idx_reg - IW'(1);
                    mem_wr_data = mem_rd_data;
                end
                if (more)
                begin
                    mem_rd_en     = 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = idx_reg[IW-1:0];
                    idx_next      = idx_reg + CW'(1);
                end
                else
                begin
                    pend_next = 1'b0;
                    if (!pend_reg)
                    begin
                        count_next = count_reg - CW'(1);
                    end
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_pos_next    = pos_reg;
                    out_count_next  = POS_W'(count_reg);
                end
            end
            default:
            begin
                pend_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            idx_reg       <= idx_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg         <= op_next;
        key_reg        <= key_next;
        pend_idx_reg   <= pend_idx_next;
        status_reg     <= status_next;
        pos_reg        <= pos_next;
        out_status_reg <= out_status_next;
        out_pos_reg    <= out_pos_next;
        out_count_reg  <= out_count_next;
    end

    assign req.ready       = (state_reg == S_IDLE);
    assign rsp.valid       = out_valid_reg;
    assign rsp.status      = out_status_reg;
    assign rsp.position    = out_pos_reg;
    assign rsp.count_after = out_count_reg;

endmodule

>>> rtl/ukl_chk.sv
// Port-level checker for the unordered key list table, bound to the top level.
// Depends on ukl_pkg and assert_macros.svh.
`include "assert_macros.svh"

module ukl_chk
    import ukl_pkg::*;
#(
    parameter int CAPACITY = CAPACITY_DEF
)(
    input logic              clk,
    input logic              rst_n,
    input logic              req_valid,
    input logic              req_ready,
    input logic              rsp_valid,
    input logic              rsp_ready,
    input logic [STAT_W-1:0] rsp_status,
    input logic [POS_W-1:0]  rsp_position,
    input logic [POS_W-1:0]  rsp_count_after
);

    localparam logic [POS_W-1:0] CAP_LOW = POS_W'(CAPACITY);

    logic req_fire;
    logic rsp_stall;
    logic rsp_reject;

    assign req_fire   = req_valid && req_ready;
    assign rsp_stall  = rsp_valid && !rsp_ready;
    assign rsp_reject = rsp_valid && (rsp_status == ST_NOT_FOUND ||
                                      rsp_status == ST_FULL ||
                                      rsp_status == ST_DUPLICATE);

    // one request in flight: no accept right after an accept
    `ASSERT_NEXT(a_one_in_flight, clk, rst_n, req_fire, !req_ready)
    // a stalled response word holds
    `ASSERT_NEXT(a_rsp_hold, clk, rst_n, rsp_stall,
        rsp_valid && $stable(rsp_status) && $stable(rsp_position) &&
        $stable(rsp_count_after))
    // refused or missed requests report slot zero
    `ASSERT_IMPLIES(a_reject_pos, clk, rst_n, rsp_reject, rsp_position == '0)
    // table full only when the count is at capacity
    `ASSERT_IMPLIES(a_full_count, clk, rst_n, rsp_valid && rsp_status == ST_FULL,
        rsp_count_after == CAP_LOW)

endmodule

bind unordered_key_list_table ukl_chk #(
    .CAPACITY (CAPACITY)
) u_ukl_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_status      (rsp.status),
    .rsp_position    (rsp.position),
    .rsp_count_after (rsp.count_after)
);
